// ===== hw/rtl/rme_pkg.sv =====
// Shared types, constants and codes for the RSA modular exponentiation engine.
// No dependencies; every other file of the block imports this package.
package rme_pkg;

  // Default width of the exponent and modulus registers.
  localparam int unsigned MOD_WIDTH_DEF   = 16;
  // Default depth of the queue between the front end and the engine.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Fixed field widths of the stream items.
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned REF_W       = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd2;

  // Operation selected by each request.
  typedef enum logic [MODE_W-1:0] {
    MODE_ENCRYPT = 2'd0,
    MODE_DECRYPT = 2'd1,
    MODE_SIGN    = 2'd2,
    MODE_VERIFY  = 2'd3
  } mode_e;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } eng_state_e;

  // A classified request as it waits in the queue (exponent travels beside it).
  typedef struct packed {
    mode_e              mode;
    logic [DATA_W-1:0]  base;
    logic [REF_W-1:0]   ref_byte;
    logic               last;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

  // Status of the serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

// ===== hw/rtl/rsa_modexp_engine_unit.sv =====
// Each request raises a 16-bit word (only its low byte in encrypt and sign modes) to a
// configured exponent modulo a configured modulus by right-to-left square-and-multiply,
// in one of four modes (encrypt, decrypt, sign, verify), and returns one result. A
// request is popped from the queue and its base reduced modulo the modulus. Each exponent
// bit below the top one then costs one square, and each set bit one multiply. Each of
// these is a pass on the single bit-serial modular multiplier, which handles one request
// at a time. A base that reduces to zero, or a modulus below two, ends the request early.
// The queue (two entries by default) keeps accepting requests while the engine works,
// and an output register holds a finished result until it is taken.
// Configuration must be written only while the block is idle; the block itself does
// not enforce this.
// Depends on rme_pkg, rme_front, rme_queue and rme_engine.
module rsa_modexp_engine_unit import rme_pkg::*; #(
  parameter int unsigned MOD_WIDTH   = MOD_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MOD_WIDTH-1:0]   cfg_data_i,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] data_in, [23:16] reference_byte
  input  logic [MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
  input  logic                   s_axis_tlast,   // last_item
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] value_out, [16] match,
                                                 // [17] all_match, [23:18] zero
  output logic                   m_axis_tlast    // last_out
);

  localparam int unsigned QW = ITEM_W + MOD_WIDTH;

  logic                 push, full, q_valid, q_pop;
  item_t                f_item, q_item;
  logic [MOD_WIDTH-1:0] f_exp, q_exp, modulus;
  logic [QW-1:0]        q_rdata;

  rme_front #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .s_last_i    (s_axis_tlast),
    .push_o      (push),
    .full_i      (full),
    .item_o      (f_item),
    .exp_o       (f_exp),
    .modulus_o   (modulus)
  );

  rme_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_exp, f_item}),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign q_item = item_t'(q_rdata[ITEM_W-1:0]);
  assign q_exp  = q_rdata[QW-1:ITEM_W];

  rme_engine #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_item_i  (q_item),
    .q_exp_i   (q_exp),
    .mod_i     (modulus),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/rme_front.sv =====
// Front end: configuration registers, input handshake and request classification.
// Depends on rme_pkg; feeds the request queue.
module rme_front import rme_pkg::*; #(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MOD_WIDTH-1:0]   cfg_data_i,
  // Input stream.
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [IN_TDATA_W-1:0]  s_data_i,
  input  logic [MODE_W-1:0]      s_user_i,
  input  logic                   s_last_i,
  // Toward the queue.
  output logic                   push_o,
  input  logic                   full_i,
  output item_t                  item_o,
  output logic [MOD_WIDTH-1:0]   exp_o,
  // Modulus, read by the engine.
  output logic [MOD_WIDTH-1:0]   modulus_o
);

  logic [MOD_WIDTH-1:0] pub_exp_q, priv_exp_q, modulus_q;
  mode_e                mode;
  logic [DATA_W-1:0]    data_in;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pub_exp_q  <= MOD_WIDTH'(1);
      priv_exp_q <= MOD_WIDTH'(1);
      modulus_q  <= MOD_WIDTH'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PUBLIC_EXP:  pub_exp_q  <= cfg_data_i;
        CFG_PRIVATE_EXP: priv_exp_q <= cfg_data_i;
        CFG_MODULUS:     modulus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept a request whenever the queue has room.
  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;
  assign modulus_o = modulus_q;

  // Classify: pick the base width and the exponent from the mode.
  assign mode    = mode_e'(s_user_i);
  assign data_in = s_data_i[DATA_W-1:0];
  always_comb begin
    item_o.mode     = mode;
    item_o.ref_byte = s_data_i[DATA_W +: REF_W];
    item_o.last     = s_last_i;
    item_o.base     = data_in;
    exp_o           = pub_exp_q;
    case (mode)
      MODE_ENCRYPT: item_o.base = {8'd0, data_in[7:0]};
      MODE_DECRYPT: exp_o = priv_exp_q;
      MODE_SIGN: begin
        item_o.base = {8'd0, data_in[7:0]};
        exp_o       = priv_exp_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rme_queue.sv =====
// Small request queue between the front end and the exponentiation engine.
// Depends on rme_pkg for its default width and depth.
module rme_queue import rme_pkg::*; #(
  parameter int unsigned WIDTH = ITEM_W,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // The front end never pushes into a full queue, the engine never pops an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CNT_W'(DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

endmodule

// ===== hw/rtl/rme_mulmod.sv =====
// Bit-serial modular multiplier: r = a * b mod m, one multiplier bit per cycle.
// Depends on rme_pkg; shared by base reduction, multiply and square steps.
module rme_mulmod import rme_pkg::*; #(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int unsigned OPW       = (MOD_WIDTH > DATA_W) ? MOD_WIDTH : DATA_W,
  parameter int unsigned CNT_W     = $clog2(OPW + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MOD_WIDTH-1:0] a_i,      // multiplicand, below m
  input  logic [OPW-1:0]       b_i,      // multiplier, left aligned
  input  logic [CNT_W-1:0]     nbits_i,  // number of multiplier bits to use
  input  logic [MOD_WIDTH-1:0] mod_i,
  output mul_sts_t             sts_o,
  output logic [MOD_WIDTH-1:0] result_o
);

  logic [MOD_WIDTH-1:0] r_q, r_d, a_q;
  logic [OPW-1:0]       b_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [MOD_WIDTH:0]   dbl, sum, mod_ext;
  logic [MOD_WIDTH-1:0] dbl_red;

  // One double-and-add step with a conditional subtraction after the double and after the add.
  always_comb begin
    mod_ext = {1'b0, mod_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? MOD_WIDTH'(dbl - mod_ext) : MOD_WIDTH'(dbl);
    sum     = {1'b0, dbl_red} + {1'b0, a_q};
    if (b_q[OPW-1]) begin
      r_d = (sum >= mod_ext) ? MOD_WIDTH'(sum - mod_ext) : MOD_WIDTH'(sum);
    end else begin
      r_d = dbl_red;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= b_q << 1;
    end
  end

  // Bit counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= nbits_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = r_q;

endmodule

// ===== hw/rtl/rme_engine.sv =====
// Back end: square-and-multiply sequencer, result formatting and verify tracking.
// Depends on rme_pkg and rme_mulmod; drains the request queue.
module rme_engine import rme_pkg::*; #(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // From the queue.
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  item_t                  q_item_i,
  input  logic [MOD_WIDTH-1:0]   q_exp_i,
  input  logic [MOD_WIDTH-1:0]   mod_i,
  // Result stream.
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [OUT_TDATA_W-1:0] m_data_o,
  output logic                   m_last_o
);

  localparam int unsigned OPW   = (MOD_WIDTH > DATA_W) ? MOD_WIDTH : DATA_W;
  localparam int unsigned CNT_W = $clog2(OPW + 1);

  eng_state_e           state_q, state_d;
  item_t                item_q, item_d;
  logic [MOD_WIDTH-1:0] exp_q, exp_d, acc_q, acc_d, base_q, base_d, res_q, res_d;
  logic                 ovalid_q, ovalid_d, run_q, run_d;
  logic [DATA_W-1:0]    oval_q, oval_d;
  logic                 omatch_q, omatch_d, oall_q, oall_d, olast_q, olast_d;

  logic                 mul_start;
  logic [MOD_WIDTH-1:0] mul_a, mul_res;
  logic [OPW-1:0]       mul_b;
  logic [CNT_W-1:0]     mul_n;
  mul_sts_t             mul_sts;
  logic                 mod_small, is_verify, match;
  logic [DATA_W-1:0]    val16;

  rme_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .nbits_i  (mul_n),
    .mod_i    (mod_i),
    .sts_o    (mul_sts),
    .result_o (mul_res)
  );

  // A modulus of zero or one leaves nothing but zero.
  assign mod_small = (mod_i <= MOD_WIDTH'(1));

  // Result formatting for the output register.
  assign is_verify = (item_q.mode == MODE_VERIFY);
  assign match     = is_verify && (res_q == MOD_WIDTH'(item_q.ref_byte));
  always_comb begin
    val16 = DATA_W'(res_q);
    if (item_q.mode == MODE_DECRYPT) begin
      val16 = {8'd0, val16[7:0]};
    end
  end

  // Sequencer: next state, operand select and output register load.
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    exp_d     = exp_q;
    acc_d     = acc_q;
    base_d    = base_q;
    res_d     = res_q;
    run_d     = run_q;
    ovalid_d  = ovalid_q && !m_ready_i;
    oval_d    = oval_q;
    omatch_d  = omatch_q;
    oall_d    = oall_q;
    olast_d   = olast_q;
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = OPW'(base_q) << (OPW - MOD_WIDTH);
    mul_n     = CNT_W'(MOD_WIDTH);
    case (state_q)
      ST_IDLE: begin
        // Reduce the base: shift its bits through the multiplier with a = 1.
        mul_a = MOD_WIDTH'(1);
        mul_b = OPW'(q_item_i.base) << (OPW - DATA_W);
        mul_n = CNT_W'(DATA_W);
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          exp_d   = q_exp_i;
          if (mod_small) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_sts.done) begin
          if (mul_res == '0) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            base_d  = mul_res;
            acc_d   = MOD_WIDTH'(1);
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        // Right to left: multiply on a set bit, then square and shift.
        if (exp_q == '0) begin
          res_d   = acc_q;
          state_d = ST_OUT;
        end else if (exp_q[0]) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end else begin
          mul_a     = base_q;
          mul_start = 1'b1;
          state_d   = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          acc_d    = mul_res;
          exp_d[0] = 1'b0;
          state_d  = ST_STEP;
        end
      end
      ST_SQR: begin
        if (mul_sts.done) begin
          base_d  = mul_res;
          exp_d   = exp_q >> 1;
          state_d = ST_STEP;
        end
      end
      ST_OUT: begin
        // Load the output register once it is free or being drained.
        if (!ovalid_q || m_ready_i) begin
          ovalid_d = 1'b1;
          oval_d   = val16;
          omatch_d = match;
          oall_d   = is_verify ? (run_q && match) : run_q;
          olast_d  = item_q.last;
          if (item_q.last) begin
            run_d = 1'b1;
          end else if (is_verify) begin
            run_d = run_q && match;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      run_q    <= 1'b1;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      run_q    <= run_d;
    end
  end

  // Datapath and output payload registers.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    exp_q    <= exp_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    res_q    <= res_d;
    oval_q   <= oval_d;
    omatch_q <= omatch_d;
    oall_q   <= oall_d;
    olast_q  <= olast_d;
  end

  assign m_valid_o = ovalid_q;
  assign m_data_o  = {6'd0, oall_q, omatch_q, oval_q};
  assign m_last_o  = olast_q;

  // The shared multiplier is never restarted while it is still working.
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier started while busy");
  // Accumulator and running base stay reduced below the modulus.
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (acc_q < mod_i))
    else $error("accumulator not reduced");
  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (base_q < mod_i))
    else $error("base not reduced");

endmodule
